### sv/dmpa_pkg.sv
// Package of the DNA multi-pattern automaton: widths, command and status
// codes, and the types passed between the front and back modules.
// No dependencies.
package dmpa_pkg;

	localparam int NODE_W       = 10;
	localparam int MAX_NODES    = 1 << NODE_W;
	localparam int MAX_PATTERNS = 10;
	localparam int DEPTH_W      = 11;
	localparam int CMD_W        = 3;
	localparam int ROW_W        = 4 * NODE_W;

	localparam logic [DEPTH_W-1:0] DEPTH_SAT = {DEPTH_W{1'b1}};
	localparam logic [DEPTH_W-1:0] LEN_RESET = DEPTH_W'(1024);

	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_BUILD   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_MATCH   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESTART = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;

	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_INSERT,
		OP_BUILD,
		OP_MATCH,
		OP_RESTART,
		OP_NOP
	} op_kind_t;

	typedef struct packed {
		op_kind_t                kind;
		logic [1:0]              symbol;
		logic                    last;
		logic                    pat_ok;
		logic [MAX_PATTERNS-1:0] pat_bit;
	} op_t;

	typedef logic [3:0][NODE_W-1:0] row_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [MAX_PATTERNS-1:0] mask;
		logic [NODE_W-1:0]       node;
		logic [NODE_W-1:0]       used;
	} res_t;

endpackage

### sv/dmpa_ifs.sv
// Valid/ready channel interfaces for input words and result words.
// Depends on dmpa_pkg.
interface dmpa_in_if;
	logic                          valid;
	logic                          ready;
	logic [dmpa_pkg::CMD_W-1:0]    command;
	logic [1:0]                    symbol;
	logic [3:0]                    pattern_number;
	logic                          last_symbol;

	modport source(output valid, command, symbol, pattern_number, last_symbol, input ready);
	modport sink(input valid, command, symbol, pattern_number, last_symbol, output ready);
endinterface

interface dmpa_out_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        status;
	logic [dmpa_pkg::MAX_PATTERNS-1:0] match_mask;
	logic [dmpa_pkg::NODE_W-1:0]       current_node;
	logic [dmpa_pkg::NODE_W-1:0]       nodes_used;

	modport source(output valid, status, match_mask, current_node, nodes_used, input ready);
	modport sink(input valid, status, match_mask, current_node, nodes_used, output ready);
endinterface

### sv/dmpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmpa_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/dmpa_front.sv
// Front end: accepts input words, decodes them into operations and holds
// them in a two-entry queue for the back end. Depends on dmpa_pkg, dmpa_ifs.
module dmpa_front (
	input  logic             clk,
	input  logic             arst_n,
	dmpa_in_if.sink          items,
	output logic             op_valid,
	input  logic             op_ready,
	output dmpa_pkg::op_t    op
);

	dmpa_pkg::op_t slot_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	dmpa_pkg::op_t dec;
	logic          push;
	logic          pop;

	always_comb begin
		dec.symbol  = items.symbol;
		dec.last    = items.last_symbol;
		dec.pat_ok  = (items.pattern_number != 4'd0) &&
			(items.pattern_number <= 4'(dmpa_pkg::MAX_PATTERNS));
		dec.pat_bit = dmpa_pkg::MAX_PATTERNS'(1) << (items.pattern_number - 4'd1);
		unique case (items.command)
			dmpa_pkg::CMD_CLEAR:   dec.kind = dmpa_pkg::OP_CLEAR;
			dmpa_pkg::CMD_INSERT:  dec.kind = dmpa_pkg::OP_INSERT;
			dmpa_pkg::CMD_BUILD:   dec.kind = dmpa_pkg::OP_BUILD;
			dmpa_pkg::CMD_MATCH:   dec.kind = dmpa_pkg::OP_MATCH;
			dmpa_pkg::CMD_RESTART: dec.kind = dmpa_pkg::OP_RESTART;
			default:               dec.kind = dmpa_pkg::OP_NOP;
		endcase
	end

	assign items.ready = (cnt_q != 2'd2);
	assign push        = items.valid && items.ready;
	assign op_valid    = (cnt_q != 2'd0);
	assign pop         = op_valid && op_ready;
	assign op          = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				slot_q[wr_q] <= dec;
				wr_q         <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

### sv/dmpa_back.sv
// Back end: executes one operation at a time against the goto, failure,
// mask and breadth-queue memories and registers the result word.
// Depends on dmpa_pkg, dmpa_ifs, dmpa_ram.
module dmpa_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          op_valid,
	output logic                          op_ready,
	input  dmpa_pkg::op_t                 op,
	input  logic [dmpa_pkg::DEPTH_W-1:0]  max_len,
	dmpa_out_if.source                    results
);

	localparam int NW = dmpa_pkg::NODE_W;
	localparam int MP = dmpa_pkg::MAX_PATTERNS;

	typedef enum logic [3:0] {
		S_IDLE, S_INS_ROW, S_INS_ZERO, S_INS_LAST, S_INS_MASK,
		S_MAT_ROW, S_MAT_MASK, S_BLD_ROOT, S_BLD_HEAD, S_BLD_X,
		S_BLD_FAIL, S_BLD_T, S_BLD_CH, S_BLD_MT, S_BLD_MU, S_BLD_WR
	} state_t;

	state_t                        state_q;
	dmpa_pkg::op_t                 cur_q;
	logic [NW-1:0]                 ins_cur_q;
	logic [dmpa_pkg::DEPTH_W-1:0]  depth_q;
	logic [NW-1:0]                 nc_q;
	logic [NW-1:0]                 mc_q;
	logic                          built_q;
	dmpa_pkg::row_t                root_row_q;
	logic [MP-1:0]                 root_mask_q;
	logic [NW:0]                   head_q;
	logic [NW:0]                   tail_q;
	logic [1:0]                    ch_q;
	logic [NW-1:0]                 x_q;
	dmpa_pkg::row_t                row_x_q;
	dmpa_pkg::row_t                row_t_q;
	logic [MP-1:0]                 mt_q;
	logic [1:0]                    status_q;
	logic                          g_root_q;
	logic                          m_root_q;
	logic                          out_valid_q;
	dmpa_pkg::res_t                out_q;

	logic                          g_we, m_we, f_we, q_we;
	logic [NW-1:0]                 g_waddr, g_raddr, m_waddr, m_raddr;
	logic [NW-1:0]                 f_waddr, f_raddr, q_waddr, q_raddr;
	dmpa_pkg::row_t                g_wdata;
	logic [dmpa_pkg::ROW_W-1:0]    g_rdata;
	logic [MP-1:0]                 m_wdata, m_rdata;
	logic [NW-1:0]                 f_wdata, f_rdata, q_wdata, q_rdata;

	dmpa_pkg::row_t                grow;
	logic [MP-1:0]                 mrd;
	logic [NW-1:0]                 nxt, nc_inc, u_ch, t_ch, root_u;
	logic [dmpa_pkg::DEPTH_W-1:0]  depth_inc;
	logic                          full, set_ok, tail_room;

	dmpa_ram #(.WIDTH(dmpa_pkg::ROW_W), .DEPTH(dmpa_pkg::MAX_NODES)) u_goto (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.raddr(g_raddr), .rdata(g_rdata));
	dmpa_ram #(.WIDTH(MP), .DEPTH(dmpa_pkg::MAX_NODES)) u_mask (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata));
	dmpa_ram #(.WIDTH(NW), .DEPTH(dmpa_pkg::MAX_NODES)) u_fail (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rdata));
	dmpa_ram #(.WIDTH(NW), .DEPTH(dmpa_pkg::MAX_NODES)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata));

	// Node zero lives in flip-flops so that reset and clear empty it at once.
	assign grow      = g_root_q ? root_row_q : dmpa_pkg::row_t'(g_rdata);
	assign mrd       = m_root_q ? root_mask_q : m_rdata;
	assign nxt       = grow[cur_q.symbol];
	assign nc_inc    = nc_q + NW'(1);
	assign full      = (nc_q == {NW{1'b1}});
	assign depth_inc = (depth_q < dmpa_pkg::DEPTH_SAT) ?
		depth_q + dmpa_pkg::DEPTH_W'(1) : depth_q;
	assign set_ok    = cur_q.last && (depth_q <= max_len) && cur_q.pat_ok;
	assign u_ch      = row_x_q[ch_q];
	assign t_ch      = row_t_q[ch_q];
	assign root_u    = root_row_q[ch_q];
	assign tail_room = !tail_q[NW];
	assign op_ready  = (state_q == S_IDLE) && !out_valid_q;

	assign results.valid        = out_valid_q;
	assign results.status       = out_q.status;
	assign results.match_mask   = out_q.mask;
	assign results.current_node = out_q.node;
	assign results.nodes_used   = out_q.used;

	always_comb begin
		g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_raddr = '0;
		m_we = 1'b0; m_waddr = '0; m_wdata = '0; m_raddr = '0;
		f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
		q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (op.kind == dmpa_pkg::OP_MATCH) begin
					g_raddr = mc_q;
				end else begin
					g_raddr = ins_cur_q;
				end
			end
			S_INS_ROW: begin
				if (nxt == '0 && !full) begin
					g_we             = 1'b1;
					g_waddr          = ins_cur_q;
					g_wdata          = grow;
					g_wdata[cur_q.symbol] = nc_inc;
					m_we             = 1'b1;
					m_waddr          = nc_inc;
				end
			end
			S_INS_ZERO: begin
				g_we    = 1'b1;
				g_waddr = ins_cur_q;
			end
			S_INS_LAST: begin
				m_raddr = ins_cur_q;
			end
			S_INS_MASK: begin
				m_we    = 1'b1;
				m_waddr = ins_cur_q;
				m_wdata = mrd | cur_q.pat_bit;
			end
			S_MAT_ROW: begin
				m_raddr = nxt;
			end
			S_MAT_MASK: begin
			end
			S_BLD_ROOT: begin
				if (root_u != '0) begin
					f_we    = 1'b1;
					f_waddr = root_u;
					q_we    = tail_room;
					q_waddr = tail_q[NW-1:0];
					q_wdata = root_u;
				end
			end
			S_BLD_HEAD: begin
				q_raddr = head_q[NW-1:0];
			end
			S_BLD_X: begin
				f_raddr = q_rdata;
				g_raddr = q_rdata;
			end
			S_BLD_FAIL: begin
				g_raddr = f_rdata;
			end
			S_BLD_T: begin
			end
			S_BLD_CH: begin
				m_raddr = t_ch;
			end
			S_BLD_MT: begin
				m_raddr = u_ch;
			end
			S_BLD_MU: begin
				m_we    = 1'b1;
				m_waddr = u_ch;
				m_wdata = mrd | mt_q;
				f_we    = 1'b1;
				f_waddr = u_ch;
				f_wdata = t_ch;
				q_we    = tail_room;
				q_waddr = tail_q[NW-1:0];
				q_wdata = u_ch;
			end
			S_BLD_WR: begin
				g_we    = 1'b1;
				g_waddr = x_q;
				g_wdata = row_x_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= '0;
			ins_cur_q   <= '0;
			depth_q     <= '0;
			nc_q        <= '0;
			mc_q        <= '0;
			built_q     <= 1'b0;
			root_row_q  <= '0;
			root_mask_q <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			ch_q        <= '0;
			x_q         <= '0;
			row_x_q     <= '0;
			row_t_q     <= '0;
			mt_q        <= '0;
			status_q    <= dmpa_pkg::ST_OK;
			g_root_q    <= 1'b0;
			m_root_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			g_root_q <= (g_raddr == '0);
			m_root_q <= (m_raddr == '0);
			if (g_we && g_waddr == '0) begin
				root_row_q <= g_wdata;
			end
			if (m_we && m_waddr == '0) begin
				root_mask_q <= m_wdata;
			end
			if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (op_valid && op_ready) begin
						cur_q <= op;
						unique case (op.kind)
							dmpa_pkg::OP_CLEAR: begin
								nc_q        <= '0;
								ins_cur_q   <= '0;
								depth_q     <= '0;
								mc_q        <= '0;
								built_q     <= 1'b0;
								root_row_q  <= '0;
								root_mask_q <= '0;
								out_valid_q <= 1'b1;
								out_q       <= '{dmpa_pkg::ST_OK, '0, '0, '0};
							end
							dmpa_pkg::OP_INSERT: begin
								if (built_q) begin
									out_valid_q <= 1'b1;
									out_q <= '{dmpa_pkg::ST_REFUSED, '0, ins_cur_q, nc_q};
								end else begin
									depth_q  <= depth_inc;
									status_q <= dmpa_pkg::ST_OK;
									state_q  <= (depth_inc <= max_len) ? S_INS_ROW : S_INS_LAST;
								end
							end
							dmpa_pkg::OP_BUILD: begin
								if (built_q) begin
									out_valid_q <= 1'b1;
									out_q       <= '{dmpa_pkg::ST_OK, '0, '0, nc_q};
								end else begin
									ch_q    <= '0;
									head_q  <= '0;
									tail_q  <= '0;
									state_q <= S_BLD_ROOT;
								end
							end
							dmpa_pkg::OP_MATCH: begin
								state_q <= S_MAT_ROW;
							end
							dmpa_pkg::OP_RESTART: begin
								mc_q        <= '0;
								out_valid_q <= 1'b1;
								out_q       <= '{dmpa_pkg::ST_OK, '0, '0, nc_q};
							end
							default: begin
								out_valid_q <= 1'b1;
								out_q       <= '{dmpa_pkg::ST_OK, '0, '0, nc_q};
							end
						endcase
					end
				end
				S_INS_ROW: begin
					if (nxt != '0) begin
						ins_cur_q <= nxt;
						state_q   <= S_INS_LAST;
					end else if (full) begin
						status_q <= dmpa_pkg::ST_FULL;
						depth_q  <= dmpa_pkg::DEPTH_SAT;
						state_q  <= S_INS_LAST;
					end else begin
						nc_q      <= nc_inc;
						ins_cur_q <= nc_inc;
						state_q   <= S_INS_ZERO;
					end
				end
				S_INS_ZERO: begin
					state_q <= S_INS_LAST;
				end
				S_INS_LAST: begin
					if (set_ok) begin
						state_q <= S_INS_MASK;
					end else begin
						out_valid_q <= 1'b1;
						out_q       <= '{status_q, '0, ins_cur_q, nc_q};
						state_q     <= S_IDLE;
						if (cur_q.last) begin
							ins_cur_q <= '0;
							depth_q   <= '0;
						end
					end
				end
				S_INS_MASK: begin
					out_valid_q <= 1'b1;
					out_q       <= '{status_q, '0, ins_cur_q, nc_q};
					ins_cur_q   <= '0;
					depth_q     <= '0;
					state_q     <= S_IDLE;
				end
				S_MAT_ROW: begin
					mc_q    <= nxt;
					state_q <= S_MAT_MASK;
				end
				S_MAT_MASK: begin
					out_valid_q <= 1'b1;
					out_q       <= '{dmpa_pkg::ST_OK, mrd, mc_q, nc_q};
					state_q     <= S_IDLE;
				end
				S_BLD_ROOT: begin
					if (root_u != '0 && tail_room) begin
						tail_q <= tail_q + (NW+1)'(1);
					end
					ch_q <= ch_q + 2'd1;
					if (ch_q == 2'd3) begin
						state_q <= S_BLD_HEAD;
					end
				end
				S_BLD_HEAD: begin
					if (head_q == tail_q) begin
						built_q     <= 1'b1;
						out_valid_q <= 1'b1;
						out_q       <= '{dmpa_pkg::ST_OK, '0, '0, nc_q};
						state_q     <= S_IDLE;
					end else begin
						head_q  <= head_q + (NW+1)'(1);
						state_q <= S_BLD_X;
					end
				end
				S_BLD_X: begin
					x_q     <= q_rdata;
					state_q <= S_BLD_FAIL;
				end
				S_BLD_FAIL: begin
					row_x_q <= grow;
					state_q <= S_BLD_T;
				end
				S_BLD_T: begin
					row_t_q <= grow;
					ch_q    <= '0;
					state_q <= S_BLD_CH;
				end
				S_BLD_CH: begin
					if (u_ch == '0) begin
						row_x_q[ch_q] <= t_ch;
						ch_q          <= ch_q + 2'd1;
						if (ch_q == 2'd3) begin
							state_q <= S_BLD_WR;
						end
					end else begin
						state_q <= S_BLD_MT;
					end
				end
				S_BLD_MT: begin
					mt_q    <= mrd;
					state_q <= S_BLD_MU;
				end
				S_BLD_MU: begin
					if (tail_room) begin
						tail_q <= tail_q + (NW+1)'(1);
					end
					ch_q    <= ch_q + 2'd1;
					state_q <= (ch_q == 2'd3) ? S_BLD_WR : S_BLD_CH;
				end
				S_BLD_WR: begin
					state_q <= S_BLD_HEAD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/dna_multi_pattern_automaton_unit.sv
// Top level of the DNA multi-pattern automaton: configuration register,
// front end and back end. Depends on dmpa_pkg, dmpa_ifs, dmpa_front, dmpa_back.
//
// Input words arrive on the items channel (command, symbol, pattern number,
// last-symbol flag); every word yields exactly one result word on the
// results channel (status, match mask, node reached, highest node number).
// The max_pattern_length register sits at APB address 0; the user must write it
// only while the block is idle, which the block itself does not enforce.
// A two-entry queue separates decoding from execution, and the back end
// runs one word at a time. Clear, restart, unknown commands, refused inserts
// and a repeated build are answered straight from the idle state; a match,
// an accepted insert and a first build step through back-end memory reads.
// Reset empties the trie, clears the cursors and the built flag, and sets
// max_pattern_length to 1024; no memory sweep is needed. While the receiver
// holds results.ready low, the finished word waits in the output register,
// the back end stops, and the front queue keeps taking up to two words.
module dna_multi_pattern_automaton_unit (
	input  logic        clk,
	input  logic        arst_n,
	dmpa_in_if.sink     items,
	dmpa_out_if.source  results,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [dmpa_pkg::DEPTH_W-1:0] max_len_q;
	logic                         op_valid;
	logic                         op_ready;
	dmpa_pkg::op_t                op;
	logic                         reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == 1'b0);
	assign prdata  = reg_sel ? 32'(max_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= dmpa_pkg::LEN_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			max_len_q <= pwdata[dmpa_pkg::DEPTH_W-1:0];
		end
	end

	dmpa_front u_front (
		.clk(clk), .arst_n(arst_n), .items(items),
		.op_valid(op_valid), .op_ready(op_ready), .op(op));

	dmpa_back u_back (
		.clk(clk), .arst_n(arst_n), .op_valid(op_valid), .op_ready(op_ready),
		.op(op), .max_len(max_len_q), .results(results));

endmodule

### dv/dna_multi_pattern_automaton_unit_test.sv
// Testbench of dna_multi_pattern_automaton_unit: drives command words, predicts every
// result word with its own automaton model and checks them in order.
// Depends on dmpa_pkg, dmpa_ifs and dna_multi_pattern_automaton_unit.
`timescale 1ns / 1ps

module dna_multi_pattern_automaton_unit_test;

	localparam logic [2:0] ADDR_MAX_LEN = 3'd0;
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam int STALL_LIMIT = 40000;
	localparam int NW = dmpa_pkg::NODE_W;
	localparam int MN = dmpa_pkg::MAX_NODES;
	localparam int MP = dmpa_pkg::MAX_PATTERNS;
	localparam int DW = dmpa_pkg::DEPTH_W;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	dmpa_in_if items();
	dmpa_out_if results();

	dna_multi_pattern_automaton_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items.sink),
		.results(results.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic [NW-1:0] goto_tbl [0:4*MN-1];
	logic [NW-1:0] fail_tbl [0:MN-1];
	logic [MP-1:0] mask_tbl [0:MN-1];
	logic [NW-1:0] bfs_order [0:MN-1];
	logic [NW-1:0] node_cnt;
	logic [NW-1:0] ins_cur;
	logic [DW-1:0] ins_depth;
	logic [NW-1:0] match_cur;
	logic built;
	logic [DW-1:0] max_len;

	dmpa_pkg::res_t pending_results[$];
	int errors;
	int words_sent;
	int send_idle;
	int recv_stall;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void link_automaton();
		int head;
		int tail;
		logic [NW-1:0] x;
		logic [NW-1:0] fx;
		logic [NW-1:0] u;
		logic [NW-1:0] t;
		head = 0;
		tail = 0;
		fail_tbl[0] = '0;
		for (int c = 0; c < 4; c++) begin
			u = goto_tbl[c];
			if (u != 0 && tail < MN) begin
				fail_tbl[u] = '0;
				bfs_order[tail] = u;
				tail++;
			end
		end
		while (head < tail) begin
			x = bfs_order[head];
			head++;
			fx = fail_tbl[x];
			for (int c = 0; c < 4; c++) begin
				u = goto_tbl[int'(x) * 4 + c];
				t = goto_tbl[int'(fx) * 4 + c];
				if (u == 0) begin
					goto_tbl[int'(x) * 4 + c] = t;
				end else begin
					if (tail < MN) begin
						bfs_order[tail] = u;
						tail++;
					end
					fail_tbl[u] = t;
					mask_tbl[u] = mask_tbl[u] | mask_tbl[t];
				end
			end
		end
		built = 1'b1;
	endfunction

	function automatic dmpa_pkg::res_t step_automaton(logic [2:0] cmd, logic [1:0] sym,
			logic [3:0] pat, logic last);
		dmpa_pkg::res_t r;
		int idx;
		logic [NW-1:0] nxt;
		r = '0;
		case (cmd)
			dmpa_pkg::CMD_CLEAR: begin
				for (int c = 0; c < 4; c++) goto_tbl[c] = '0;
				mask_tbl[0] = '0;
				node_cnt = '0;
				ins_cur = '0;
				ins_depth = '0;
				match_cur = '0;
				built = 1'b0;
			end
			dmpa_pkg::CMD_INSERT: begin
				if (built) begin
					r.status = dmpa_pkg::ST_REFUSED;
					r.node = ins_cur;
				end else begin
					if (ins_depth != dmpa_pkg::DEPTH_SAT) ins_depth++;
					if (ins_depth <= max_len) begin
						idx = int'(ins_cur) * 4 + int'(sym);
						nxt = goto_tbl[idx];
						if (nxt == 0) begin
							if (int'(node_cnt) + 1 >= MN) begin
								r.status = dmpa_pkg::ST_FULL;
								ins_depth = dmpa_pkg::DEPTH_SAT;
							end else begin
								node_cnt++;
								nxt = node_cnt;
								for (int c = 0; c < 4; c++)
									goto_tbl[int'(nxt) * 4 + c] = '0;
								mask_tbl[nxt] = '0;
								goto_tbl[idx] = nxt;
							end
						end
						if (r.status == dmpa_pkg::ST_OK) ins_cur = nxt;
					end
					r.node = ins_cur;
					if (last) begin
						if (ins_depth <= max_len && pat >= 1 && pat <= MP)
							mask_tbl[ins_cur] = mask_tbl[ins_cur] |
								(MP'(1) << (pat - 1));
						ins_cur = '0;
						ins_depth = '0;
					end
				end
			end
			dmpa_pkg::CMD_BUILD: begin
				if (!built) link_automaton();
			end
			dmpa_pkg::CMD_MATCH: begin
				match_cur = goto_tbl[int'(match_cur) * 4 + int'(sym)];
				r.node = match_cur;
				r.mask = mask_tbl[match_cur];
			end
			dmpa_pkg::CMD_RESTART: begin
				match_cur = '0;
			end
			default: begin
			end
		endcase
		r.used = node_cnt;
		return r;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("Mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		results.ready <= arst_n && ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		dmpa_pkg::res_t want;
		if (results.valid && results.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (results.status !== want.status)
					report_mismatch("status", results.status, want.status);
				if (results.match_mask !== want.mask)
					report_mismatch("match_mask", results.match_mask, want.mask);
				if (results.current_node !== want.node)
					report_mismatch("current_node", results.current_node, want.node);
				if (results.nodes_used !== want.used)
					report_mismatch("nodes_used", results.nodes_used, want.used);
			end
		end
	end

	always @(posedge clk) begin
		if ((items.valid && items.ready) || (results.valid && results.ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_word(logic [2:0] cmd, logic [1:0] sym, logic [3:0] pat, logic last);
		while ($urandom_range(99) < send_idle) begin
			items.valid <= 1'b0;
			@(posedge clk);
		end
		items.valid <= 1'b1;
		items.command <= cmd;
		items.symbol <= sym;
		items.pattern_number <= pat;
		items.last_symbol <= last;
		do @(posedge clk); while (!items.ready);
		pending_results.push_back(step_automaton(cmd, sym, pat, last));
		words_sent++;
	endtask

	task automatic wait_idle();
		items.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_max_len(logic [DW-1:0] value);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_MAX_LEN;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		max_len = value;
	endtask

	task automatic test_directed();
		write_max_len(DW'(1024));
		send_word(dmpa_pkg::CMD_MATCH, 2'd3, 4'd0, 1'b0);
		send_word(dmpa_pkg::CMD_INSERT, 2'd0, 4'd1, 1'b0);
		send_word(dmpa_pkg::CMD_INSERT, 2'd1, 4'd1, 1'b0);
		send_word(dmpa_pkg::CMD_INSERT, 2'd2, 4'd1, 1'b1);
		send_word(dmpa_pkg::CMD_INSERT, 2'd1, 4'd10, 1'b0);
		send_word(dmpa_pkg::CMD_INSERT, 2'd2, 4'd10, 1'b1);
		send_word(dmpa_pkg::CMD_INSERT, 2'd3, 4'd0, 1'b1);
		send_word(dmpa_pkg::CMD_INSERT, 2'd3, 4'd15, 1'b1);
		send_word(dmpa_pkg::CMD_MATCH, 2'd0, 4'd0, 1'b0);
		send_word(dmpa_pkg::CMD_MATCH, 2'd1, 4'd0, 1'b0);
		send_word(dmpa_pkg::CMD_BUILD, 2'd0, 4'd0, 1'b0);
		send_word(dmpa_pkg::CMD_BUILD, 2'd0, 4'd0, 1'b0);
		send_word(dmpa_pkg::CMD_INSERT, 2'd0, 4'd2, 1'b1);
		send_word(dmpa_pkg::CMD_RESTART, 2'd0, 4'd0, 1'b0);
		send_word(dmpa_pkg::CMD_MATCH, 2'd0, 4'd0, 1'b0);
		send_word(dmpa_pkg::CMD_MATCH, 2'd1, 4'd0, 1'b0);
		send_word(dmpa_pkg::CMD_MATCH, 2'd2, 4'd0, 1'b0);
		send_word(dmpa_pkg::CMD_MATCH, 2'd3, 4'd0, 1'b0);
		send_word(CMD_SPARE_LO, 2'd3, 4'd15, 1'b1);
		send_word(CMD_SPARE_HI, 2'd0, 4'd0, 1'b0);
		send_word(dmpa_pkg::CMD_CLEAR, 2'd0, 4'd0, 1'b0);
		send_word(dmpa_pkg::CMD_MATCH, 2'd2, 4'd0, 1'b0);
	endtask

	task automatic test_length_limit();
		for (int lim = 0; lim < 3; lim++) begin
			write_max_len(DW'(lim));
			send_word(dmpa_pkg::CMD_CLEAR, 2'd0, 4'd0, 1'b0);
			send_word(dmpa_pkg::CMD_INSERT, 2'd2, 4'd3, 1'b1);
			send_word(dmpa_pkg::CMD_INSERT, 2'd2, 4'd4, 1'b0);
			send_word(dmpa_pkg::CMD_INSERT, 2'd1, 4'd4, 1'b1);
			send_word(dmpa_pkg::CMD_BUILD, 2'd0, 4'd0, 1'b0);
			send_word(dmpa_pkg::CMD_MATCH, 2'd2, 4'd0, 1'b0);
			send_word(dmpa_pkg::CMD_MATCH, 2'd1, 4'd0, 1'b0);
		end
	endtask

	task automatic test_table_full();
		write_max_len(dmpa_pkg::DEPTH_SAT);
		send_word(dmpa_pkg::CMD_CLEAR, 2'd0, 4'd0, 1'b0);
		for (int k = 0; k < MN + 2; k++)
			send_word(dmpa_pkg::CMD_INSERT, 2'($urandom_range(3)), 4'd5, 1'b0);
		send_word(dmpa_pkg::CMD_INSERT, 2'd0, 4'd5, 1'b1);
		send_word(dmpa_pkg::CMD_INSERT, 2'd3, 4'd6, 1'b1);
		send_word(dmpa_pkg::CMD_BUILD, 2'd0, 4'd0, 1'b0);
		for (int k = 0; k < 30; k++)
			send_word(dmpa_pkg::CMD_MATCH, 2'($urandom_range(3)), 4'd0, 1'b0);
	endtask

	task automatic test_random(int quota);
		logic [1:0] pat_sym [8][8];
		int pat_len [8];
		int n_pat;
		int pick;
		int stop_at;
		logic [3:0] num;
		stop_at = words_sent + quota;
		while (words_sent < stop_at) begin
			pick = $urandom_range(9);
			if (pick == 0) write_max_len('0);
			else if (pick == 1) write_max_len(DW'(1024));
			else if (pick == 2) write_max_len(dmpa_pkg::DEPTH_SAT);
			else write_max_len(DW'($urandom_range(1, 10)));
			send_word(dmpa_pkg::CMD_CLEAR, 2'($urandom_range(3)), 4'($urandom_range(15)),
				1'($urandom_range(1)));
			n_pat = $urandom_range(2, 8);
			for (int p = 0; p < n_pat; p++) begin
				pat_len[p] = $urandom_range(1, 8);
				num = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) :
					4'($urandom_range(1, 10));
				for (int k = 0; k < pat_len[p]; k++) begin
					pat_sym[p][k] = 2'($urandom_range(3));
					send_word(dmpa_pkg::CMD_INSERT, pat_sym[p][k], num, k == pat_len[p] - 1);
				end
				if ($urandom_range(9) == 0)
					send_word(dmpa_pkg::CMD_MATCH, 2'($urandom_range(3)), 4'd0, 1'b0);
			end
			send_word(dmpa_pkg::CMD_BUILD, 2'($urandom_range(3)), 4'($urandom_range(15)),
				1'($urandom_range(1)));
			if ($urandom_range(3) == 0) send_word(dmpa_pkg::CMD_BUILD, 2'd0, 4'd0, 1'b0);
			if ($urandom_range(3) == 0)
				send_word(dmpa_pkg::CMD_INSERT, 2'($urandom_range(3)),
					4'($urandom_range(15)), 1'($urandom_range(1)));
			send_word(dmpa_pkg::CMD_RESTART, 2'($urandom_range(3)), 4'($urandom_range(15)),
				1'($urandom_range(1)));
			for (int m = 0; m < 6; m++) begin
				pick = $urandom_range(n_pat - 1);
				for (int k = 0; k < pat_len[pick]; k++)
					send_word(dmpa_pkg::CMD_MATCH, pat_sym[pick][k], 4'($urandom_range(15)),
						1'($urandom_range(1)));
				send_word(dmpa_pkg::CMD_MATCH, 2'($urandom_range(3)), 4'd0, 1'b0);
				if ($urandom_range(14) == 0)
					send_word(dmpa_pkg::CMD_RESTART, 2'd0, 4'd0, 1'b0);
				if ($urandom_range(29) == 0)
					send_word(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
						2'($urandom_range(3)), 4'($urandom_range(15)),
						1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		items.valid = 1'b0;
		items.command = dmpa_pkg::CMD_CLEAR;
		items.symbol = '0;
		items.pattern_number = '0;
		items.last_symbol = 1'b0;
		results.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_MAX_LEN;
		pwdata = '0;
		errors = 0;
		words_sent = 0;
		quiet_cycles = 0;
		send_idle = 0;
		recv_stall = 0;
		for (int i = 0; i < 4 * MN; i++) goto_tbl[i] = '0;
		for (int i = 0; i < MN; i++) begin
			fail_tbl[i] = '0;
			mask_tbl[i] = '0;
			bfs_order[i] = '0;
		end
		node_cnt = '0;
		ins_cur = '0;
		ins_depth = '0;
		match_cur = '0;
		built = 1'b0;
		max_len = dmpa_pkg::LEN_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_length_limit();
		test_table_full();
		test_random(40);
		send_idle = 56;
		recv_stall = 0;
		test_random(40);
		send_idle = 0;
		recv_stall = 56;
		test_random(40);
		send_idle = 35;
		recv_stall = 35;
		test_random(40);

		wait_idle();
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
